@@ rtl/core/cmsg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cmsg_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int SLOTS       = 7;

    localparam logic [7:0] SYNC_BYTE = 8'h3A;

    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    typedef logic [7:0]  byte_t;
    typedef logic [2:0]  fill_t;
    typedef logic [6:0]  len_t;
    typedef logic [10:0] can_id_t;

    typedef struct packed {
        can_id_t    frame_id;
        logic [3:0] frame_dlc;
        byte_t      data0;
        byte_t      data1;
        byte_t      data2;
        byte_t      data3;
        byte_t      data4;
        byte_t      data5;
        byte_t      data6;
        byte_t      data7;
        logic       last_frame;
    } frame_t;

endpackage

`default_nettype wire

@@ rtl/core/can_message_segmenter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// A frame caused by an input beat is written into the output queue and offered on m_ behind any frame still waiting.
// One input beat per cycle while the output queue has room; the frame assembler updates on each accepted beat.
// A two-entry output queue keeps s_ready high while one frame waits on m_ready.
// Reset (aresetn low, synchronous) clears the message state and empties the queue.
module can_message_segmenter_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [7:0]  s_node_addr,
    input  wire logic [6:0]  s_payload_len,
    input  wire logic [7:0]  s_command,
    input  wire logic [7:0]  s_frame_tag,
    input  wire logic [10:0] s_std_id,
    input  wire logic [7:0]  s_payload_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [10:0]      m_frame_id,
    output logic [3:0]       m_frame_dlc,
    output logic [7:0]       m_data0,
    output logic [7:0]       m_data1,
    output logic [7:0]       m_data2,
    output logic [7:0]       m_data3,
    output logic [7:0]       m_data4,
    output logic [7:0]       m_data5,
    output logic [7:0]       m_data6,
    output logic [7:0]       m_data7,
    output logic             m_last_frame
);

    logic             beat_en;
    logic             emit;
    logic             has_room;
    cmsg_pkg::frame_t new_frame;
    cmsg_pkg::frame_t head_frame;

    assign s_ready = has_room;
    assign beat_en = s_valid & has_room;

    cmsg_assembler u_assembler (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .beat_en      (beat_en),
        .req_type     (s_req_type),
        .node_addr    (s_node_addr),
        .payload_len  (s_payload_len),
        .command      (s_command),
        .frame_tag    (s_frame_tag),
        .std_id       (s_std_id),
        .payload_byte (s_payload_byte),
        .emit         (emit),
        .frame        (new_frame)
    );

    cmsg_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (emit),
        .push_frame (new_frame),
        .has_room   (has_room),
        .head_valid (m_valid),
        .pop        (m_valid & m_ready),
        .head_frame (head_frame)
    );

    assign m_frame_id   = head_frame.frame_id;
    assign m_frame_dlc  = head_frame.frame_dlc;
    assign m_data0      = head_frame.data0;
    assign m_data1      = head_frame.data1;
    assign m_data2      = head_frame.data2;
    assign m_data3      = head_frame.data3;
    assign m_data4      = head_frame.data4;
    assign m_data5      = head_frame.data5;
    assign m_data6      = head_frame.data6;
    assign m_data7      = head_frame.data7;
    assign m_last_frame = head_frame.last_frame;

endmodule

`default_nettype wire

@@ rtl/core/cmsg_assembler.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cmsg_assembler (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             beat_en,
    input  wire logic             req_type,
    input  wire logic [7:0]       node_addr,
    input  wire logic [6:0]       payload_len,
    input  wire logic [7:0]       command,
    input  wire logic [7:0]       frame_tag,
    input  wire logic [10:0]      std_id,
    input  wire logic [7:0]       payload_byte,
    output logic                  emit,
    output cmsg_pkg::frame_t      frame
);

    cmsg_pkg::byte_t   bytes_reg [cmsg_pkg::SLOTS];
    cmsg_pkg::byte_t   bytes_next [cmsg_pkg::SLOTS];
    cmsg_pkg::byte_t   fbytes [cmsg_pkg::SLOTS];
    cmsg_pkg::fill_t   fill_reg, fill_next;
    cmsg_pkg::len_t    left_reg, left_next;
    logic              active_reg, active_next;
    cmsg_pkg::can_id_t id_reg, id_next;
    cmsg_pkg::byte_t   tag_reg, tag_next;

    cmsg_pkg::len_t    len_clamped;
    cmsg_pkg::len_t    left_dec;
    cmsg_pkg::fill_t   fill_inc;
    cmsg_pkg::fill_t   frame_fill;
    logic              frame_last;

    always_comb begin
        if (int'(payload_len) > cmsg_pkg::MAX_PAYLOAD) begin
            len_clamped = 7'(cmsg_pkg::MAX_PAYLOAD);
        end else begin
            len_clamped = payload_len;
        end
        left_dec = (left_reg != '0) ? left_reg - 7'd1 : left_reg;
        fill_inc = fill_reg + 3'd1;
    end

    always_comb begin
        bytes_next  = bytes_reg;
        fill_next   = fill_reg;
        left_next   = left_reg;
        active_next = active_reg;
        id_next     = id_reg;
        tag_next    = tag_reg;
        fbytes      = bytes_reg;
        frame_fill  = fill_reg;
        frame_last  = 1'b0;
        emit        = 1'b0;

        if (beat_en) begin
            if (req_type == cmsg_pkg::REQ_START) begin
                fbytes[0] = cmsg_pkg::SYNC_BYTE;
                fbytes[1] = node_addr;
                fbytes[2] = {1'b0, len_clamped};
                fbytes[3] = command;
                fbytes[4] = '0;
                fbytes[5] = '0;
                fbytes[6] = '0;
                frame_fill = 3'd4;
                id_next    = std_id;
                tag_next   = frame_tag;
                left_next  = len_clamped;
                if (len_clamped == '0) begin
                    emit        = 1'b1;
                    frame_last  = 1'b1;
                    active_next = 1'b0;
                end else begin
                    active_next = 1'b1;
                end
            end else if (active_reg) begin
                // slots past the fill point are always zero, so append in place
                if (int'(fill_reg) < cmsg_pkg::SLOTS) begin
                    fbytes[fill_reg] = payload_byte;
                    frame_fill       = fill_inc;
                end
                left_next = left_dec;
                if (left_dec == '0) begin
                    emit        = 1'b1;
                    frame_last  = 1'b1;
                    active_next = 1'b0;
                end else if (int'(frame_fill) >= cmsg_pkg::SLOTS) begin
                    emit = 1'b1;
                end
            end
            if (emit) begin
                for (int k = 0; k < cmsg_pkg::SLOTS; k++) begin
                    bytes_next[k] = '0;
                end
                fill_next = '0;
            end else begin
                bytes_next = fbytes;
                fill_next  = frame_fill;
            end
        end
    end

    always_comb begin
        frame.frame_id   = id_next;
        frame.frame_dlc  = {1'b0, frame_fill} + 4'd1;
        frame.data0      = tag_next;
        frame.data1      = fbytes[0];
        frame.data2      = fbytes[1];
        frame.data3      = fbytes[2];
        frame.data4      = fbytes[3];
        frame.data5      = fbytes[4];
        frame.data6      = fbytes[5];
        frame.data7      = fbytes[6];
        frame.last_frame = frame_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < cmsg_pkg::SLOTS; k++) begin
                bytes_reg[k] <= '0;
            end
            fill_reg   <= '0;
            left_reg   <= '0;
            active_reg <= 1'b0;
            id_reg     <= '0;
            tag_reg    <= '0;
        end else begin
            bytes_reg  <= bytes_next;
            fill_reg   <= fill_next;
            left_reg   <= left_next;
            active_reg <= active_next;
            id_reg     <= id_next;
            tag_reg    <= tag_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cmsg_out_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cmsg_out_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire cmsg_pkg::frame_t push_frame,
    output logic                  has_room,
    output logic                  head_valid,
    input  wire logic             pop,
    output cmsg_pkg::frame_t      head_frame
);

    cmsg_pkg::frame_t entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign has_room   = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_frame = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic              req_type;
        cmsg_pkg::byte_t   node_addr;
        cmsg_pkg::len_t    payload_len;
        cmsg_pkg::byte_t   command;
        cmsg_pkg::byte_t   frame_tag;
        cmsg_pkg::can_id_t std_id;
        cmsg_pkg::byte_t   payload_byte;
    } seg_req_t;

    // Tracks the message assembler and holds the frames still owed by the block.
    class frame_scoreboard;
        cmsg_pkg::byte_t   slots[cmsg_pkg::SLOTS];
        cmsg_pkg::fill_t   fill;
        cmsg_pkg::len_t    left;
        bit                active;
        cmsg_pkg::can_id_t held_id;
        cmsg_pkg::byte_t   held_tag;
        cmsg_pkg::frame_t  owed_frames[$];
        int                errors;
        int                frames_checked;

        function new();
            clear_slots();
            left           = '0;
            active         = 1'b0;
            held_id        = '0;
            held_tag       = '0;
            errors         = 0;
            frames_checked = 0;
        endfunction

        function void clear_slots();
            foreach (slots[k]) slots[k] = '0;
            fill = '0;
        endfunction

        function void push(cmsg_pkg::byte_t b);
            if (fill < cmsg_pkg::SLOTS) begin
                slots[fill] = b;
                fill++;
            end
        endfunction

        function void emit(bit last);
            cmsg_pkg::frame_t f;
            f.frame_id   = held_id;
            f.frame_dlc  = {1'b0, fill} + 4'd1;
            f.data0      = held_tag;
            f.data1      = (fill > 0) ? slots[0] : '0;
            f.data2      = (fill > 1) ? slots[1] : '0;
            f.data3      = (fill > 2) ? slots[2] : '0;
            f.data4      = (fill > 3) ? slots[3] : '0;
            f.data5      = (fill > 4) ? slots[4] : '0;
            f.data6      = (fill > 5) ? slots[5] : '0;
            f.data7      = (fill > 6) ? slots[6] : '0;
            f.last_frame = last;
            owed_frames.push_back(f);
            clear_slots();
        endfunction

        function void note_request(seg_req_t r);
            cmsg_pkg::len_t eff;
            if (r.req_type == cmsg_pkg::REQ_START) begin
                eff = (r.payload_len > cmsg_pkg::MAX_PAYLOAD) ?
                      7'(cmsg_pkg::MAX_PAYLOAD) : r.payload_len;
                // a new start drops whatever the previous message collected
                clear_slots();
                held_id  = r.std_id;
                held_tag = r.frame_tag;
                push(cmsg_pkg::SYNC_BYTE);
                push(r.node_addr);
                push({1'b0, eff});
                push(r.command);
                left = eff;
                if (left == 0) begin
                    active = 1'b0;
                    emit(1'b1);
                end else begin
                    active = 1'b1;
                end
            end else if (active) begin
                push(r.payload_byte);
                if (left > 0) left--;
                if (left == 0) begin
                    active = 1'b0;
                    emit(1'b1);
                end else if (fill >= cmsg_pkg::SLOTS) begin
                    emit(1'b0);
                end
            end
        endfunction

        function void cmp(string name, logic [10:0] exp_v, logic [10:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_frame(cmsg_pkg::frame_t got);
            cmsg_pkg::frame_t want;
            if (owed_frames.size() == 0) begin
                $error("frame with no expectation: id %0h dlc %0d",
                       got.frame_id, got.frame_dlc);
                errors++;
                return;
            end
            want = owed_frames.pop_front();
            frames_checked++;
            cmp("frame_id",   want.frame_id,        got.frame_id);
            cmp("frame_dlc",  11'(want.frame_dlc),  11'(got.frame_dlc));
            cmp("data0",      11'(want.data0),      11'(got.data0));
            cmp("data1",      11'(want.data1),      11'(got.data1));
            cmp("data2",      11'(want.data2),      11'(got.data2));
            cmp("data3",      11'(want.data3),      11'(got.data3));
            cmp("data4",      11'(want.data4),      11'(got.data4));
            cmp("data5",      11'(want.data5),      11'(got.data5));
            cmp("data6",      11'(want.data6),      11'(got.data6));
            cmp("data7",      11'(want.data7),      11'(got.data7));
            cmp("last_frame", 11'(want.last_frame), 11'(got.last_frame));
        endfunction

        function int pending();
            return owed_frames.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_req_type;
    logic [7:0]  s_node_addr;
    logic [6:0]  s_payload_len;
    logic [7:0]  s_command;
    logic [7:0]  s_frame_tag;
    logic [10:0] s_std_id;
    logic [7:0]  s_payload_byte;
    logic        m_valid;
    logic        m_ready;
    logic [10:0] m_frame_id;
    logic [3:0]  m_frame_dlc;
    logic [7:0]  m_data0;
    logic [7:0]  m_data1;
    logic [7:0]  m_data2;
    logic [7:0]  m_data3;
    logic [7:0]  m_data4;
    logic [7:0]  m_data5;
    logic [7:0]  m_data6;
    logic [7:0]  m_data7;
    logic        m_last_frame;

    frame_scoreboard sb;

    int src_idle_pct;
    int snk_idle_pct;
    int hold_req;
    int beats_sent;
    int stray_sent;
    int msgs_sent;
    int msgs_clamped;
    int msgs_cut;

    can_message_segmenter_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_node_addr   (s_node_addr),
        .s_payload_len (s_payload_len),
        .s_command     (s_command),
        .s_frame_tag   (s_frame_tag),
        .s_std_id      (s_std_id),
        .s_payload_byte(s_payload_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_frame_id    (m_frame_id),
        .m_frame_dlc   (m_frame_dlc),
        .m_data0       (m_data0),
        .m_data1       (m_data1),
        .m_data2       (m_data2),
        .m_data3       (m_data3),
        .m_data4       (m_data4),
        .m_data5       (m_data5),
        .m_data6       (m_data6),
        .m_data7       (m_data7),
        .m_last_frame  (m_last_frame)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Note input beats before checking output beats within the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_request('{s_req_type, s_node_addr, s_payload_len, s_command,
                                  s_frame_tag, s_std_id, s_payload_byte});
            if (m_valid && m_ready)
                sb.check_frame('{m_frame_id, m_frame_dlc, m_data0, m_data1, m_data2,
                                 m_data3, m_data4, m_data5, m_data6, m_data7,
                                 m_last_frame});
        end
    end

    // Receiver: random backpressure, plus a long hold-off when asked.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    function automatic seg_req_t rand_fields();
        seg_req_t r;
        r.req_type     = 1'($urandom_range(1));
        r.node_addr    = 8'($urandom_range(255));
        r.payload_len  = 7'($urandom_range(127));
        r.command      = 8'($urandom_range(255));
        r.frame_tag    = 8'($urandom_range(255));
        r.std_id       = 11'($urandom_range(2047));
        r.payload_byte = 8'($urandom_range(255));
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_req(seg_req_t r);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_req_type     <= r.req_type;
        s_node_addr    <= r.node_addr;
        s_payload_len  <= r.payload_len;
        s_command      <= r.command;
        s_frame_tag    <= r.frame_tag;
        s_std_id       <= r.std_id;
        s_payload_byte <= r.payload_byte;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic send_start(cmsg_pkg::byte_t addr, cmsg_pkg::len_t len,
                              cmsg_pkg::byte_t cmd, cmsg_pkg::byte_t tag,
                              cmsg_pkg::can_id_t id);
        seg_req_t r;
        r             = rand_fields();
        r.req_type    = cmsg_pkg::REQ_START;
        r.node_addr   = addr;
        r.payload_len = len;
        r.command     = cmd;
        r.frame_tag   = tag;
        r.std_id      = id;
        send_req(r);
    endtask

    task automatic send_byte(cmsg_pkg::byte_t b);
        seg_req_t r;
        r              = rand_fields();
        r.req_type     = cmsg_pkg::REQ_PAYLOAD;
        r.payload_byte = b;
        send_req(r);
    endtask

    task automatic send_bytes(int n);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
    endtask

    // Hold the sender until every owed frame is out, then let the pipe settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic run_random(int n_items);
        int             stop_at;
        int             p;
        int             n_pay;
        cmsg_pkg::len_t len;
        stop_at = beats_sent - stray_sent + n_items;
        while (beats_sent - stray_sent < stop_at) begin
            p = $urandom_range(99);
            if (p < 55)      len = 7'($urandom_range(12));
            else if (p < 80) len = 7'($urandom_range(40, 13));
            else if (p < 94) len = 7'($urandom_range(64, 41));
            else             len = 7'($urandom_range(127, 65));
            if (len > cmsg_pkg::MAX_PAYLOAD) msgs_clamped++;
            n_pay = (len > cmsg_pkg::MAX_PAYLOAD) ? cmsg_pkg::MAX_PAYLOAD : int'(len);
            send_start(8'($urandom_range(255)), len, 8'($urandom_range(255)),
                       8'($urandom_range(255)), 11'($urandom_range(2047)));
            msgs_sent++;
            if (n_pay > 0 && $urandom_range(99) < 10) begin
                // cut the message short; the next start abandons it
                send_bytes($urandom_range(n_pay - 1));
                msgs_cut++;
            end else begin
                send_bytes(n_pay);
                if ($urandom_range(99) < 8) begin
                    p = $urandom_range(2, 1);
                    send_bytes(p);
                    stray_sent += p;
                end
            end
        end
    endtask

    initial begin
        sb             = new();
        src_idle_pct   = 20;
        snk_idle_pct   = 82;
        hold_req       = 0;
        beats_sent     = 0;
        stray_sent     = 0;
        msgs_sent      = 0;
        msgs_clamped   = 0;
        msgs_cut       = 0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_req_type     = cmsg_pkg::REQ_START;
        s_node_addr    = '0;
        s_payload_len  = '0;
        s_command      = '0;
        s_frame_tag    = '0;
        s_std_id       = '0;
        s_payload_byte = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty payload: header-only frame
        send_start(8'h00, 7'd0, 8'h00, 8'h00, 11'h000);
        // final byte fills the seventh slot
        send_start(8'hFF, 7'd3, 8'hFF, 8'hFF, 11'h7FF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        // short tail frame
        send_start(8'h5A, 7'd1, 8'h81, 8'h3C, 11'h155);
        send_byte(8'h00);
        // payload with no message open
        send_byte(8'hFF);
        // clamped length, then a restart that drops a collected byte
        send_start(8'h12, 7'd127, 8'h34, 8'h56, 11'h2AA);
        send_bytes(4);
        send_start(8'hC3, 7'd2, 8'h0F, 8'hF0, 11'h400);
        send_bytes(2);
        // two frames, the second both full and last
        send_start(8'h01, 7'd10, 8'h80, 8'h7F, 11'h001);
        send_bytes(10);
        stray_sent = 1;
        msgs_sent  = 6;
        msgs_clamped = 1;
        msgs_cut   = 1;
        drain();

        run_random(280);
        drain();

        src_idle_pct = 82;
        snk_idle_pct = 20;
        run_random(280);
        drain();

        // long receiver hold-off while the sender keeps going
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req     = 300;
        run_random(330);
        drain();
        repeat (20) @(negedge aclk);

        $display("Sent %0d beats: %0d messages (%0d clamped, %0d cut short), %0d stray bytes",
                 beats_sent, msgs_sent, msgs_clamped, msgs_cut, stray_sent);
        $display("Checked %0d frames, %0d errors", sb.frames_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/cmsg_pkg.sv
rtl/core/cmsg_assembler.sv
rtl/core/cmsg_out_queue.sv
rtl/core/can_message_segmenter_unit.sv
dv/tb_top.sv
